>>> rtl/wti_pkg.sv
package wti_pkg;

    // Reset value of the speed register: 1.5 m/s in unsigned Q8.16.
    localparam int unsigned SPEED_RST = 98304;

    // Iteration counts of the shared arithmetic unit.
    localparam int unsigned MUL_STEPS  = 32;
    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned SQRT_STEPS = 33;

    // Operations of the shared arithmetic unit.
    localparam logic [2:0] OP_MUL_ND = 3'd0;   // |t - t0| * |d|
    localparam logic [2:0] OP_DIV_P  = 3'd1;   // product / |t1 - t0|, position write-back
    localparam logic [2:0] OP_MUL_DD = 3'd2;   // |d| * |d|, added to the sum of squares
    localparam logic [2:0] OP_SQRT   = 3'd3;   // floor square root of the sum of squares
    localparam logic [2:0] OP_MUL_DS = 3'd4;   // |d| * speed
    localparam logic [2:0] OP_DIV_V  = 3'd5;   // product / norm, velocity write-back

    typedef struct packed {
        logic       accept;
        logic       wr_en;
        logic       rd_en;
        logic       ld_last;
        logic       ld_a;
        logic       ld_b;
        logic       start;
        logic [2:0] op;
        logic [1:0] axis;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic ge_last;
        logic hit;
        logic done;
    } t_sts;

endpackage

>>> rtl/wti_ctrl.sv
module wti_ctrl #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_action,
    input  logic                             i_out_stall,
    input  wti_pkg::t_sts                    i_sts,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0] i_rd_ix,
    output wti_pkg::t_cmd                    o_cmd,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] o_rd_addr,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] o_wr_addr,
    output logic                             o_in_stall,
    output logic                             o_out_valid
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHKLAST = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_LDA     = 4'd3;
    localparam logic [3:0] S_LDB     = 4'd4;
    localparam logic [3:0] S_LDB2    = 4'd5;
    localparam logic [3:0] S_GO      = 4'd6;
    localparam logic [3:0] S_WMND    = 4'd7;
    localparam logic [3:0] S_WDIVP   = 4'd8;
    localparam logic [3:0] S_WMDD    = 4'd9;
    localparam logic [3:0] S_SQGO    = 4'd10;
    localparam logic [3:0] S_WSQ     = 4'd11;
    localparam logic [3:0] S_WMDS    = 4'd12;
    localparam logic [3:0] S_WDV     = 4'd13;
    localparam logic [3:0] S_OUT     = 4'd14;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    logic [AW-1:0] r_b, n_b;
    logic [1:0]    r_k, n_k;
    logic          r_ovld, n_ovld;
    logic [CW-1:0] last;

    assign last       = r_count - CW'(1);
    assign o_wr_addr  = r_count[AW-1:0];
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_j       = r_j;
        n_b       = r_b;
        n_k       = r_k;
        n_ovld    = r_ovld;
        o_cmd     = '0;
        o_rd_addr = '0;
        if (r_ovld && !i_out_stall) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_action) begin
                        if (r_count < CW'(MAX_WAYPOINTS)) begin
                            o_cmd.wr_en = 1'b1;
                            n_count     = r_count + CW'(1);
                        end
                    end else if (r_count != '0) begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = last[AW-1:0];
                        n_state     = S_CHKLAST;
                    end
                end
            end
            S_CHKLAST: begin
                if (i_sts.ge_last || last == '0) begin
                    o_cmd.ld_last = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = '0;
                    n_j         = CW'(1);
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_b     = i_rd_ix;
                    n_state = S_LDA;
                end else if (r_j > last) begin
                    n_b     = AW'(1);
                    n_state = S_LDA;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_j[AW-1:0];
                    n_j         = r_j + CW'(1);
                end
            end
            S_LDA: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_b - AW'(1);
                n_state     = S_LDB;
            end
            S_LDB: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_b;
                o_cmd.ld_a  = 1'b1;
                n_state     = S_LDB2;
            end
            S_LDB2: begin
                o_cmd.ld_b = 1'b1;
                n_k        = 2'd0;
                n_state    = S_GO;
            end
            S_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = wti_pkg::OP_MUL_ND;
                o_cmd.axis  = r_k;
                n_state     = S_WMND;
            end
            S_WMND: begin
                if (i_sts.done) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = wti_pkg::OP_DIV_P;
                    o_cmd.axis  = r_k;
                    n_state     = S_WDIVP;
                end
            end
            S_WDIVP: begin
                if (i_sts.done) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = wti_pkg::OP_MUL_DD;
                    o_cmd.axis  = r_k;
                    n_state     = S_WMDD;
                end
            end
            S_WMDD: begin
                if (i_sts.done) begin
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = S_SQGO;
                    end else begin
                        n_k         = r_k + 2'd1;
                        o_cmd.start = 1'b1;
                        o_cmd.op    = wti_pkg::OP_MUL_ND;
                        o_cmd.axis  = r_k + 2'd1;
                        n_state     = S_WMND;
                    end
                end
            end
            S_SQGO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = wti_pkg::OP_SQRT;
                n_state     = S_WSQ;
            end
            S_WSQ: begin
                if (i_sts.done) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = wti_pkg::OP_MUL_DS;
                    o_cmd.axis  = r_k;
                    n_state     = S_WMDS;
                end
            end
            S_WMDS: begin
                if (i_sts.done) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = wti_pkg::OP_DIV_V;
                    o_cmd.axis  = r_k;
                    n_state     = S_WDV;
                end
            end
            S_WDV: begin
                if (i_sts.done) begin
                    if (r_k == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_k         = r_k + 2'd1;
                        o_cmd.start = 1'b1;
                        o_cmd.op    = wti_pkg::OP_MUL_DS;
                        o_cmd.axis  = r_k + 2'd1;
                        n_state     = S_WMDS;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovld || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovld         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_j     <= '0;
            r_b     <= '0;
            r_k     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_j     <= n_j;
            r_b     <= n_b;
            r_k     <= n_k;
            r_ovld  <= n_ovld;
        end
    end

endmodule

>>> rtl/wti_dp.sv
module wti_dp #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wti_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0] i_wr_addr,
    input  logic [31:0]                      i_sample_time,
    input  logic signed [31:0]               i_wp_x,
    input  logic signed [31:0]               i_wp_y,
    input  logic signed [31:0]               i_wp_z,
    input  logic                             i_cfg_we,
    input  logic [23:0]                      i_cfg_data,
    output wti_pkg::t_sts                    o_sts,
    output logic [$clog2(MAX_WAYPOINTS)-1:0] o_rd_ix,
    output logic signed [31:0]               o_out_x,
    output logic signed [31:0]               o_out_y,
    output logic signed [31:0]               o_out_z,
    output logic signed [24:0]               o_vel_x,
    output logic signed [24:0]               o_vel_y,
    output logic signed [24:0]               o_vel_z,
    output logic                             o_at_end
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam logic signed [34:0] POS_MAX = 35'sh07FFFFFFF;
    localparam logic signed [34:0] POS_MIN = 35'sh780000000;

    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] n;
        n = v[32] ? (~v + 33'd1) : v;
        return n[31:0];
    endfunction

    // Waypoint table: time, x, y, z packed in one word.
    logic [127:0]  mem [MAX_WAYPOINTS];
    logic [127:0]  r_rd;
    logic [AW-1:0] r_rd_ix;
    logic          r_rd_ok;

    logic [31:0]        rd_t;
    logic [31:0]        rd_p [3];

    logic [23:0]        r_speed;
    logic [31:0]        r_t, r_prev_t, r_t0;
    logic [31:0]        r_p0 [3];
    logic signed [32:0] r_d [3];
    logic signed [32:0] r_num, r_den;
    logic [65:0]        r_sumsq;
    logic [32:0]        r_norm;
    logic [31:0]        r_rp [3];
    logic [24:0]        r_rv [3];
    logic               r_rend;

    // Shared multiply / divide / square-root unit.
    logic        r_busy, r_done;
    logic [6:0]  r_cnt;
    logic [2:0]  r_op;
    logic [1:0]  r_axis;
    logic [31:0] r_mc, r_mp;
    logic [63:0] r_acc;
    logic [63:0] r_quo;
    logic [32:0] r_rem, r_dvs;
    logic [65:0] r_rad;
    logic [32:0] r_root;
    logic [34:0] r_srem;

    logic [32:0] mul_sum;
    logic [33:0] div_sh;
    logic [34:0] div_diff;
    logic [35:0] sq_sh;
    logic [36:0] sq_diff;
    logic signed [32:0] d_sel, wb_d;
    logic        wb_neg;
    logic [32:0] wb_qc;
    logic signed [34:0] wb_p0e, wb_sum;
    logic [31:0] wb_pos;
    logic [24:0] wb_vel;

    assign rd_t    = r_rd[127:96];
    assign rd_p[0] = r_rd[95:64];
    assign rd_p[1] = r_rd[63:32];
    assign rd_p[2] = r_rd[31:0];

    assign o_sts.ge_last = (r_t >= rd_t);
    assign o_sts.hit     = r_rd_ok && (r_rd_ix != '0) && (r_t >= r_prev_t) && (r_t < rd_t);
    assign o_sts.done    = r_done;
    assign o_rd_ix       = r_rd_ix;

    assign d_sel    = r_d[i_cmd.axis];
    assign mul_sum  = {1'b0, r_acc[63:32]} + (r_mp[0] ? {1'b0, r_mc} : 33'd0);
    assign div_sh   = {r_rem, r_quo[63]};
    assign div_diff = {1'b0, div_sh} - {2'b00, r_dvs};
    assign sq_sh    = {r_srem[33:0], r_rad[65:64]};
    assign sq_diff  = {1'b0, sq_sh} - {2'b00, r_root[31:0], 2'b01};

    // Position: p0 + (t - t0) * d / (t1 - t0), quotient clamped, sum saturated.
    always_comb begin
        wb_d   = r_d[r_axis];
        wb_neg = r_num[32] ^ wb_d[32] ^ r_den[32];
        wb_qc  = (r_quo > 64'h1_0000_0000) ? 33'h1_0000_0000 : r_quo[32:0];
        wb_p0e = {{3{r_p0[r_axis][31]}}, r_p0[r_axis]};
        wb_sum = wb_neg ? (wb_p0e - $signed({2'b00, wb_qc}))
                        : (wb_p0e + $signed({2'b00, wb_qc}));
        if (r_den == '0) begin
            wb_pos = r_p0[r_axis];
        end else if (wb_sum > POS_MAX) begin
            wb_pos = 32'h7FFF_FFFF;
        end else if (wb_sum < POS_MIN) begin
            wb_pos = 32'h8000_0000;
        end else begin
            wb_pos = wb_sum[31:0];
        end
        if (r_norm == '0) begin
            wb_vel = '0;
        end else if (wb_d[32]) begin
            wb_vel = ~r_quo[24:0] + 25'd1;
        end else begin
            wb_vel = r_quo[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= {i_sample_time, i_wp_x, i_wp_y, i_wp_z};
        end
        if (i_cmd.rd_en) begin
            r_rd    <= mem[i_rd_addr];
            r_rd_ix <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
            r_speed <= 24'(wti_pkg::SPEED_RST);
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_op    <= wti_pkg::OP_MUL_ND;
            r_axis  <= '0;
        end else begin
            r_rd_ok <= i_cmd.rd_en;
            if (i_cfg_we) begin
                r_speed <= i_cfg_data;
            end
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_axis <= i_cmd.axis;
                case (i_cmd.op)
                    wti_pkg::OP_DIV_P, wti_pkg::OP_DIV_V: begin
                        r_cnt <= 7'(wti_pkg::DIV_STEPS);
                    end
                    wti_pkg::OP_SQRT: begin
                        r_cnt <= 7'(wti_pkg::SQRT_STEPS);
                    end
                    default: begin
                        r_cnt <= 7'(wti_pkg::MUL_STEPS);
                    end
                endcase
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 7'd1;
                r_busy <= (r_cnt != 7'd1);
                r_done <= (r_cnt == 7'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_ok) begin
            r_prev_t <= rd_t;
        end
        if (i_cmd.accept) begin
            r_t <= i_sample_time;
        end
        if (i_cmd.ld_last) begin
            for (int k = 0; k < 3; k++) begin
                r_rp[k] <= rd_p[k];
                r_rv[k] <= '0;
            end
            r_rend <= (r_t >= rd_t);
        end
        if (i_cmd.ld_a) begin
            r_t0   <= rd_t;
            r_rend <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_p0[k] <= rd_p[k];
            end
        end
        if (i_cmd.ld_b) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= $signed({rd_p[k][31], rd_p[k]}) - $signed({r_p0[k][31], r_p0[k]});
            end
            r_num   <= $signed({1'b0, r_t}) - $signed({1'b0, r_t0});
            r_den   <= $signed({1'b0, rd_t}) - $signed({1'b0, r_t0});
            r_sumsq <= '0;
        end

        // Results of a finished operation.
        if (r_done) begin
            case (r_op)
                wti_pkg::OP_DIV_P:  r_rp[r_axis] <= wb_pos;
                wti_pkg::OP_MUL_DD: r_sumsq <= r_sumsq + {2'b00, r_acc};
                wti_pkg::OP_SQRT:   r_norm <= r_root;
                wti_pkg::OP_DIV_V:  r_rv[r_axis] <= wb_vel;
                default: begin
                end
            endcase
        end

        if (i_cmd.start) begin
            case (i_cmd.op)
                wti_pkg::OP_MUL_ND: begin
                    r_mc  <= mag33(r_num);
                    r_mp  <= mag33(d_sel);
                    r_acc <= '0;
                end
                wti_pkg::OP_MUL_DD: begin
                    r_mc  <= mag33(d_sel);
                    r_mp  <= mag33(d_sel);
                    r_acc <= '0;
                end
                wti_pkg::OP_MUL_DS: begin
                    r_mc  <= mag33(d_sel);
                    r_mp  <= {8'd0, r_speed};
                    r_acc <= '0;
                end
                wti_pkg::OP_DIV_P: begin
                    r_quo <= r_acc;
                    r_rem <= '0;
                    r_dvs <= {1'b0, mag33(r_den)};
                end
                wti_pkg::OP_DIV_V: begin
                    r_quo <= r_acc;
                    r_rem <= '0;
                    r_dvs <= r_norm;
                end
                wti_pkg::OP_SQRT: begin
                    r_rad  <= r_sumsq;
                    r_root <= '0;
                    r_srem <= '0;
                end
                default: begin
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                wti_pkg::OP_DIV_P, wti_pkg::OP_DIV_V: begin
                    if (!div_diff[34]) begin
                        r_rem <= div_diff[32:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= div_sh[32:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                end
                wti_pkg::OP_SQRT: begin
                    r_rad <= {r_rad[63:0], 2'b00};
                    if (!sq_diff[36]) begin
                        r_srem <= sq_diff[34:0];
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_srem <= sq_sh[34:0];
                        r_root <= {r_root[31:0], 1'b0};
                    end
                end
                default: begin
                    r_acc <= {mul_sum, r_acc[31:1]};
                    r_mp  <= {1'b0, r_mp[31:1]};
                end
            endcase
        end

        if (i_cmd.out_load) begin
            o_out_x  <= r_rp[0];
            o_out_y  <= r_rp[1];
            o_out_z  <= r_rp[2];
            o_vel_x  <= r_rv[0];
            o_vel_y  <= r_rv[1];
            o_vel_z  <= r_rv[2];
            o_at_end <= r_rend;
        end
    end

endmodule

>>> rtl/waypoint_trajectory_interpolator.sv
// Piecewise-linear trajectory interpolator over a table of waypoints.
// Input channel (i_in_valid / o_in_stall): each beat is either an append
// (i_action = 0) that stores a waypoint time and Q16.16 position, or a query
// (i_action = 1) for the position and velocity at i_sample_time. Appends
// beyond MAX_WAYPOINTS entries are dropped. A query on an empty table gives
// no result; every other query gives exactly one result beat on the output
// channel (o_out_valid / i_out_stall).
// A query at or after the last waypoint time, or with a single waypoint,
// takes the last waypoint directly, with no scan or arithmetic. Any other
// query scans the time column linearly, one entry per cycle through the
// table's read port, then runs one shared shift-add multiplier, restoring
// divider and square root unit.
// The block takes one item at a time. A finished result waits in the output
// register while the next item is accepted; if the receiver still stalls when
// the next result is ready, the block holds and keeps o_in_stall high.
// Reset clears the waypoint count, the output valid and sets the speed
// register to 1.5 m/s; table contents are not cleared. Write i_cfg_data
// only while the block is idle.
module waypoint_trajectory_interpolator #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [31:0]        i_sample_time,
    input  logic signed [31:0] i_wp_x,
    input  logic signed [31:0] i_wp_y,
    input  logic signed [31:0] i_wp_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [24:0] o_vel_x,
    output logic signed [24:0] o_vel_y,
    output logic signed [24:0] o_vel_z,
    output logic               o_at_end,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_WAYPOINTS);

    // Controller and datapath talk through these command and status groups and the table addresses.
    wti_pkg::t_cmd cmd;
    wti_pkg::t_sts sts;
    logic [AW-1:0] rd_addr, wr_addr, rd_ix;

    wti_ctrl #(
        .MAX_WAYPOINTS(MAX_WAYPOINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .i_rd_ix     (rd_ix),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    wti_dp #(
        .MAX_WAYPOINTS(MAX_WAYPOINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_sample_time (i_sample_time),
        .i_wp_x        (i_wp_x),
        .i_wp_y        (i_wp_y),
        .i_wp_z        (i_wp_z),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_sts         (sts),
        .o_rd_ix       (rd_ix),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_vel_x       (o_vel_x),
        .o_vel_y       (o_vel_y),
        .o_vel_z       (o_vel_z),
        .o_at_end      (o_at_end)
    );

`ifndef SYNTH
    // A new result only appears after the block has been busy on a query.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a query in progress");

    // At or past the last waypoint the velocity is zero.
    a_end_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_at_end) |-> (o_vel_x == '0 && o_vel_y == '0 && o_vel_z == '0))
        else $error("nonzero velocity at end of trajectory");

    // A controller read is never issued while an arithmetic operation runs.
    a_no_read_in_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !cmd.rd_en)
        else $error("table read during arithmetic");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH  = 1024;
    localparam int STALL_LIMIT  = 20000;  // idle cycles before the run is declared hung
    localparam int SETTLE_TICKS = 20;     // covers an append or an empty query still in flight

    // One expected or observed result beat.
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [24:0] vx;
        logic signed [24:0] vy;
        logic signed [24:0] vz;
        logic               at_end;
    } t_pose;

    // Scoreboard: keeps its own copy of the waypoint table and the speed
    // register, predicts the pose for every accepted query on a non-empty table
    // and checks the result beats against the queue of predicted poses in order.
    class TrajectoryScoreboard;
        logic [31:0]        wp_time[$];
        logic signed [31:0] wp_x[$];
        logic signed [31:0] wp_y[$];
        logic signed [31:0] wp_z[$];
        logic [23:0]        speed;
        t_pose              pending[$];
        int                 errors;
        int                 appends;
        int                 dropped;
        int                 queries;
        int                 checked;

        function new();
            speed = 24'(wti_pkg::SPEED_RST);
        endfunction

        function automatic logic [63:0] magnitude(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        function automatic logic [63:0] floor_sqrt(logic [127:0] s);
            logic [127:0] r;
            logic [127:0] c;
            r = '0;
            for (int b = 33; b >= 0; b--) begin
                c = r | (128'd1 << b);
                if (c * c <= s) r = c;
            end
            return r[63:0];
        endfunction

        // Position on the segment: exact product, truncating divide, the
        // offset clamped to 2^32 and the sum saturated to 32 bits.
        function automatic logic signed [31:0] lerp(longint p0, longint d, longint num,
                                                    longint den);
            logic [127:0] q;
            longint       r;
            bit           neg;
            if (den == 0) return 32'(p0);
            neg = ((num < 0) != (d < 0)) != (den < 0);
            q = (128'(magnitude(num)) * 128'(magnitude(d))) / 128'(magnitude(den));
            if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
            r = neg ? p0 - longint'(q) : p0 + longint'(q);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return 32'(r);
        endfunction

        function void note_beat(bit is_query, logic [31:0] t, logic signed [31:0] x,
                                logic signed [31:0] y, logic signed [31:0] z);
            t_pose        e;
            int           last;
            int           seg;
            longint       p0[3];
            longint       d[3];
            longint       num;
            longint       den;
            logic [127:0] sq_sum;
            logic [63:0]  norm;
            logic [127:0] q;
            logic signed [31:0] p[3];
            logic signed [24:0] v[3];
            if (!is_query) begin
                if (wp_time.size() < TABLE_DEPTH) begin
                    wp_time = {wp_time, t};
                    wp_x    = {wp_x, x};
                    wp_y    = {wp_y, y};
                    wp_z    = {wp_z, z};
                    appends++;
                end else begin
                    dropped++;
                end
                return;
            end
            queries++;
            if (wp_time.size() == 0) return;
            last = wp_time.size() - 1;
            if (t >= wp_time[last] || last == 0) begin
                // Hold the final waypoint; a lone waypoint also holds it before its time.
                e = '{wp_x[last], wp_y[last], wp_z[last], 0, 0, 0, t >= wp_time[last]};
                pending = {pending, e};
                return;
            end
            // First bracketing segment, falling back to segment 0.
            seg = 0;
            for (int i = 0; i < last; i++) begin
                if (t >= wp_time[i] && t < wp_time[i + 1]) begin
                    seg = i;
                    break;
                end
            end
            p0[0] = wp_x[seg];
            p0[1] = wp_y[seg];
            p0[2] = wp_z[seg];
            d[0] = longint'(wp_x[seg + 1]) - p0[0];
            d[1] = longint'(wp_y[seg + 1]) - p0[1];
            d[2] = longint'(wp_z[seg + 1]) - p0[2];
            num = longint'({32'd0, t}) - longint'({32'd0, wp_time[seg]});
            den = longint'({32'd0, wp_time[seg + 1]}) - longint'({32'd0, wp_time[seg]});
            sq_sum = '0;
            for (int k = 0; k < 3; k++) begin
                p[k] = lerp(p0[k], d[k], num, den);
                sq_sum += 128'(magnitude(d[k])) * 128'(magnitude(d[k]));
                v[k] = '0;
            end
            norm = floor_sqrt(sq_sum);
            if (norm != 0) begin
                for (int k = 0; k < 3; k++) begin
                    q = (128'(magnitude(d[k])) * 128'(speed)) / 128'(norm);
                    v[k] = (d[k] < 0) ? 25'(-q) : 25'(q);
                end
            end
            e = '{p[0], p[1], p[2], v[0], v[1], v[2], 1'b0};
            pending = {pending, e};
        endfunction

        function void check_beat(t_pose got);
            t_pose w;
            if (pending.size() == 0) begin
                $error("result beat with no query outstanding");
                errors++;
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.px != w.px) begin
                $error("out_x expected %0d got %0d", w.px, got.px); errors++;
            end
            if (got.py != w.py) begin
                $error("out_y expected %0d got %0d", w.py, got.py); errors++;
            end
            if (got.pz != w.pz) begin
                $error("out_z expected %0d got %0d", w.pz, got.pz); errors++;
            end
            if (got.vx != w.vx) begin
                $error("vel_x expected %0d got %0d", w.vx, got.vx); errors++;
            end
            if (got.vy != w.vy) begin
                $error("vel_y expected %0d got %0d", w.vy, got.vy); errors++;
            end
            if (got.vz != w.vz) begin
                $error("vel_z expected %0d got %0d", w.vz, got.vz); errors++;
            end
            if (got.at_end !== w.at_end) begin
                $error("at_end expected %0d got %0d", w.at_end, got.at_end); errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [31:0]        i_sample_time;
    logic signed [31:0] i_wp_x;
    logic signed [31:0] i_wp_y;
    logic signed [31:0] i_wp_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [24:0] o_vel_x;
    logic signed [24:0] o_vel_y;
    logic signed [24:0] o_vel_z;
    logic               o_at_end;
    logic               i_cfg_we;
    logic [23:0]        i_cfg_data;

    waypoint_trajectory_interpolator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_sample_time (i_sample_time),
        .i_wp_x        (i_wp_x),
        .i_wp_y        (i_wp_y),
        .i_wp_z        (i_wp_z),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_vel_x       (o_vel_x),
        .o_vel_y       (o_vel_y),
        .o_vel_z       (o_vel_z),
        .o_at_end      (o_at_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    TrajectoryScoreboard sb = new();

    // When set, the bench inserts no gaps or stalls of its own; only the block holds beats back.
    bit          full_rate;
    int          idle_ticks;
    int          stall_run;
    bit          stall_now;
    logic [31:0] next_time;           // time stamp for the next well-formed append
    logic signed [31:0] prev_pos[3];  // last appended position, reused for zero-length segments

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        if (full_rate) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(30, 300);
    endfunction

    // Receiver: random runs of ready and stalled cycles.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_now = !full_rate && ($urandom_range(0, 2) == 0);
            stall_run = stall_now ? gap_len() + 1 : $urandom_range(1, 40);
        end
        stall_run--;
        i_out_stall <= stall_now;
    end

    // Result checking and the hang watchdog. Outputs are sampled at the edge,
    // before the block's own updates for that edge land.
    always @(posedge i_clk) begin
        t_pose got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_x, o_out_y, o_out_z, o_vel_x, o_vel_y, o_vel_z, o_at_end};
                sb.check_beat(got);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_ticks = 0;
            else
                idle_ticks++;
            if (idle_ticks >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Presents one beat after a random gap and returns at the edge where it
    // is taken. Valid stays high into the next beat when there is no gap.
    task automatic send_beat(bit is_query, logic [31:0] t, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= is_query;
        i_sample_time <= t;
        i_wp_x        <= x;
        i_wp_y        <= y;
        i_wp_z        <= z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(is_query, t, x, y, z);
    endtask

    // A query beat: the position fields carry noise that must be ignored.
    task automatic send_query(logic [31:0] t);
        send_beat(1'b1, t, $urandom, $urandom, $urandom);
    endtask

    // Holds the sender until every predicted result has come back, then lets
    // any result-free item finish before the speed register may be touched.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_speed(logic [23:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.speed = value;
    endtask

    function automatic logic signed [31:0] pick_coord(int axis);
        int r;
        r = $urandom_range(0, 9);
        if (r < 1) return prev_pos[axis];
        if (r < 3) return $urandom;
        return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endfunction

    // Mostly a waypoint later in time than the last one; sometimes a repeated
    // time (zero-duration segment) or an arbitrary one (unsorted table).
    task automatic append_random();
        logic [31:0] t;
        logic signed [31:0] p[3];
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            t = $urandom;
        else if (r == 1)
            t = next_time;
        else begin
            next_time = next_time + $urandom_range(1, 32'h000F_FFFF);
            t = next_time;
        end
        for (int k = 0; k < 3; k++) p[k] = pick_coord(k);
        // Occasionally repeat the last point whole, giving a zero-length segment.
        if ($urandom_range(0, 9) == 0)
            for (int k = 0; k < 3; k++) p[k] = prev_pos[k];
        prev_pos = p;
        send_beat(1'b0, t, p[0], p[1], p[2]);
    endtask

    // Query times cluster on the stored waypoints and inside the used time
    // range, with a share of arbitrary times and the extremes.
    task automatic query_random();
        logic [31:0] t;
        int r;
        r = $urandom_range(0, 19);
        if (r < 5 && sb.wp_time.size() > 0)
            t = sb.wp_time[$urandom_range(0, sb.wp_time.size() - 1)]
                + $urandom_range(0, 2) - 1;
        else if (r < 16)
            t = $urandom_range(0, next_time + 32'h0010_0000);
        else if (r < 18)
            t = $urandom;
        else
            t = (r == 18) ? 32'h0 : 32'hFFFF_FFFF;
        send_query(t);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 3) append_random();
            else query_random();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= 1'b0;
        i_sample_time <= '0;
        i_wp_x        <= '0;
        i_wp_y        <= '0;
        i_wp_z        <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        idle_ticks = 0;
        stall_run  = 0;
        full_rate  = 1'b0;
        next_time  = 32'h0005_0000;
        prev_pos   = '{32'sh0001_0000, -32'sh0003_0000, 32'sh7FFF_FFFF};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset speed. An empty table answers nothing.
        send_query(32'h0);
        // One waypoint at the positive and negative extremes.
        send_beat(1'b0, 32'h0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
        send_query(32'h0);              // lone waypoint, before its time
        send_query(32'h0001_0000);      // exactly at the last time
        send_query(32'hFFFF_FFFF);      // far past the end
        // A one-tick segment spanning the full range: extrapolating back to
        // time zero has to clamp and saturate in both directions.
        send_beat(1'b0, 32'h0001_0001, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0);
        send_query(32'h0);
        send_query(32'h0001_0000);
        // Same position again: a zero-length segment gives zero velocity.
        send_beat(1'b0, 32'h0003_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0);
        send_query(32'h0002_0000);
        send_beat(1'b0, 32'h0005_0000, 32'sh0001_0000, -32'sh0003_0000, 32'sh7FFF_FFFF);
        send_query(32'h0004_0001);      // ordinary interpolation with truncation
        send_query(32'h0004_FFFF);
        send_query(32'h0005_0000);
        send_query(32'h8000_0000);

        // Random phases, the speed register rewritten between them.
        drain();
        write_speed(24'd0);
        random_phase(90);
        drain();
        write_speed(24'hFF_FFFF);
        full_rate = 1'b1;
        random_phase(60);
        full_rate = 1'b0;
        random_phase(60);
        drain();
        write_speed(24'($urandom));
        random_phase(210);
        drain();
        write_speed(24'd1);

        for (int i = 0; i < 6; i++) query_random();
        send_query(sb.wp_time[sb.wp_time.size() - 1]);
        drain();
        write_speed(24'(wti_pkg::SPEED_RST));
        for (int i = 0; i < 4; i++) query_random();

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d stored waypoints (%0d appends dropped) and %0d queries,",
                 sb.appends, sb.dropped, sb.queries);
        $display("with %0d result beats compared across five speed settings.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
